@@ hw/rtl/rcw_pkg.sv @@
// Package for the RIFF/IFF chunk walker: field widths, header constants,
// the scan phase type and the result record.
// Used by the channel interfaces and by riff_chunk_walker_top.
package rcw_pkg;

  localparam int ID_W     = 32;
  localparam int SIZE_W   = 32;
  localparam int OFFSET_W = 33;

  localparam logic [OFFSET_W-1:0] HEADER_BYTES    = 33'd8;
  localparam logic [OFFSET_W-1:0] FORM_TYPE_BYTES = 33'd4;
  localparam logic [2:0]          ID_BYTES        = 3'd4;
  localparam logic [2:0]          LAST_HDR_BYTE   = 3'd7;

  typedef enum logic [1:0] {
    PH_OUTER,
    PH_SKIP,
    PH_HEADER,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [ID_W-1:0]     chunk_id;
    logic [OFFSET_W-1:0] chunk_offset;
    logic [OFFSET_W-1:0] data_offset;
    logic [OFFSET_W-1:0] data_size;
    logic                status;
    logic                last;
  } chunk_t;

endpackage

@@ hw/rtl/rcw_byte_if.sv @@
// Byte channel of the chunk walker: valid/ready handshake with one stream byte.
// Depends on rcw_pkg.
interface rcw_byte_if import rcw_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_start;
  logic       stream_end;

  modport source (output valid, data_byte, stream_start, stream_end, input ready);
  modport sink (input valid, data_byte, stream_start, stream_end, output ready);
endinterface

@@ hw/rtl/rcw_chunk_if.sv @@
// Result channel of the chunk walker: valid/ready handshake with one chunk record.
// Depends on rcw_pkg for the field widths.
interface rcw_chunk_if import rcw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ID_W-1:0]     chunk_id;
  logic [OFFSET_W-1:0] chunk_offset;
  logic [OFFSET_W-1:0] data_offset;
  logic [OFFSET_W-1:0] data_size;
  logic                status;
  logic                last;

  modport source (output valid, chunk_id, chunk_offset, data_offset, data_size, status,
                  last, input ready);
  modport sink (input valid, chunk_id, chunk_offset, data_offset, data_size, status,
                last, output ready);
endinterface

@@ hw/rtl/riff_chunk_walker_top.sv @@
// RIFF/IFF chunk walker top level: byte sink, chunk record source, byte order register.
// Depends on rcw_pkg, rcw_byte_if and rcw_chunk_if.
//
// The walker takes one container byte per cycle while input ready is high, and reports
// the outer header and then every chunk header it finds, until a chunk reaches the end
// given by the outer size or the stream ends early. Each byte is handled by the header
// shift registers, the position counter and the skip counter. When its last header byte
// is transferred, a chunk record is written to the output register, or to the one-entry
// skid register behind it while it is held; records leave through the output register.
// Bytes keep flowing while a record waits; input ready drops only when both hold one.
// There is no clearing pass after reset. Set the size byte order only between files.
module riff_chunk_walker_top import rcw_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  rcw_byte_if.sink     bytes,
  rcw_chunk_if.source  chunks,
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data
);

  logic size_big_endian;

  phase_t              phase, phase_next;
  logic [2:0]          hdr_cnt, hdr_cnt_next;
  logic [ID_W-1:0]     id_shift, id_shift_next;
  logic [SIZE_W-1:0]   size_shift, size_shift_next;
  logic [OFFSET_W-1:0] stream_pos, stream_pos_next;
  logic [OFFSET_W-1:0] skip_rem, skip_rem_next;
  logic [OFFSET_W-1:0] total_size, total_size_next;
  logic [OFFSET_W-1:0] header_offset, header_offset_next;

  phase_t              cur_phase;
  logic [2:0]          cur_cnt;
  logic [ID_W-1:0]     cur_id;
  logic [SIZE_W-1:0]   cur_size;
  logic [OFFSET_W-1:0] cur_pos, cur_skip, cur_total, cur_hdr_off;

  logic [ID_W-1:0]     id_take;
  logic [SIZE_W-1:0]   size_take;
  logic                hdr_full;
  logic [OFFSET_W-1:0] padded, skip_dec;
  logic [OFFSET_W:0]   data_end;
  logic                fin;

  chunk_t res;
  logic   res_valid;

  chunk_t out_data, skid_data;
  logic   out_valid, skid_valid;
  logic   accept, out_free;

  assign accept   = bytes.valid && bytes.ready;
  assign out_free = !out_valid || chunks.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_big_endian <= 1'b0;
    end else if (cfg_wr_en) begin
      size_big_endian <= cfg_wr_data;
    end
  end

  always_comb begin
    cur_phase   = bytes.stream_start ? PH_OUTER : phase;
    cur_cnt     = bytes.stream_start ? 3'd0 : hdr_cnt;
    cur_id      = bytes.stream_start ? '0 : id_shift;
    cur_size    = bytes.stream_start ? '0 : size_shift;
    cur_pos     = bytes.stream_start ? '0 : stream_pos;
    cur_skip    = bytes.stream_start ? '0 : skip_rem;
    cur_total   = bytes.stream_start ? '0 : total_size;
    cur_hdr_off = bytes.stream_start ? '0 : header_offset;

    id_take   = cur_id;
    size_take = cur_size;
    if (cur_cnt < ID_BYTES) begin
      id_take = {cur_id[ID_W-9:0], bytes.data_byte};
    end else if (size_big_endian) begin
      size_take = {cur_size[SIZE_W-9:0], bytes.data_byte};
    end else begin
      size_take = {bytes.data_byte, cur_size[SIZE_W-1:8]};
    end
    hdr_full = (cur_cnt == LAST_HDR_BYTE);

    padded   = {1'b0, size_take} + {{(OFFSET_W-1){1'b0}}, size_take[0]};
    data_end = {1'b0, cur_hdr_off} + {1'b0, HEADER_BYTES} + {1'b0, padded};
    fin      = data_end >= {1'b0, cur_total};
    skip_dec = (cur_skip != '0) ? cur_skip - 33'd1 : cur_skip;

    phase_next         = cur_phase;
    hdr_cnt_next       = cur_cnt;
    id_shift_next      = cur_id;
    size_shift_next    = cur_size;
    stream_pos_next    = cur_pos;
    skip_rem_next      = cur_skip;
    total_size_next    = cur_total;
    header_offset_next = cur_hdr_off;
    res                = '0;
    res_valid          = 1'b0;

    if (cur_phase != PH_DONE) begin
      stream_pos_next = cur_pos + 33'd1;
      unique case (cur_phase) inside
        PH_OUTER, PH_HEADER: begin
          id_shift_next   = id_take;
          size_shift_next = size_take;
          hdr_cnt_next    = cur_cnt + 3'd1;
          if (hdr_full) begin
            res_valid    = 1'b1;
            res.chunk_id = id_take;
            if (cur_phase == PH_OUTER) begin
              total_size_next  = HEADER_BYTES + {1'b0, size_take};
              res.chunk_offset = '0;
              res.data_size    = FORM_TYPE_BYTES;
              skip_rem_next    = FORM_TYPE_BYTES;
              phase_next       = PH_SKIP;
            end else begin
              res.chunk_offset = cur_hdr_off;
              res.data_size    = padded;
              res.last         = fin;
              if (fin) begin
                phase_next = PH_DONE;
              end else if (padded == '0) begin
                header_offset_next = stream_pos_next;
                phase_next         = PH_HEADER;
              end else begin
                skip_rem_next = padded;
                phase_next    = PH_SKIP;
              end
            end
            res.data_offset = res.chunk_offset + HEADER_BYTES;
          end
        end
        PH_SKIP: begin
          skip_rem_next = skip_dec;
          if (skip_dec == '0) begin
            header_offset_next = stream_pos_next;
            phase_next         = PH_HEADER;
          end
        end
        default: begin
          phase_next = PH_DONE;
        end
      endcase

      if (bytes.stream_end && phase_next != PH_DONE) begin
        if (!res_valid) begin
          res = '0;
        end
        res.status = 1'b1;
        res.last   = 1'b1;
        res_valid  = 1'b1;
        phase_next = PH_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_OUTER;
      hdr_cnt       <= 3'd0;
      id_shift      <= '0;
      size_shift    <= '0;
      stream_pos    <= '0;
      skip_rem      <= '0;
      total_size    <= '0;
      header_offset <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      hdr_cnt       <= hdr_cnt_next;
      id_shift      <= id_shift_next;
      size_shift    <= size_shift_next;
      stream_pos    <= stream_pos_next;
      skip_rem      <= skip_rem_next;
      total_size    <= total_size_next;
      header_offset <= header_offset_next;
    end
  end

  // A new record can only arrive while the skid register is empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_free) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= accept && res_valid;
        end
      end else if (accept && res_valid) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept && res_valid) begin
        out_data <= res;
      end
    end else if (accept && res_valid) begin
      skid_data <= res;
    end
  end

  assign bytes.ready         = !skid_valid;
  assign chunks.valid        = out_valid;
  assign chunks.chunk_id     = out_data.chunk_id;
  assign chunks.chunk_offset = out_data.chunk_offset;
  assign chunks.data_offset  = out_data.data_offset;
  assign chunks.data_size    = out_data.data_size;
  assign chunks.status       = out_data.status;
  assign chunks.last         = out_data.last;

endmodule
